// ===== hw/rtl/ibd_pkg.sv =====
package ibd_pkg;

  // Sizing of the line store and of the block counters
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_FACTOR = 16;
  localparam int MAX_HEIGHT = 4096;

  localparam int IDX_W      = $clog2(MAX_WIDTH);
  localparam int FSEL_W     = $clog2(MAX_FACTOR);
  localparam int FACTOR_W   = 5;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int LIM_W      = ((IDX_W + 1 > WIDTH_W) ? IDX_W + 1 : WIDTH_W) + 1;

  // Datapath widths
  localparam int PIX_W   = 8;
  localparam int LANE_W  = 16;
  localparam int RECIP_W = 17;
  localparam int SHIFT_W = 5;
  localparam int PROD_W  = LANE_W + RECIP_W;

  typedef enum logic [1:0] {
    REG_FACTOR       = 2'd0,
    REG_COLOR_MODE   = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  // Front of the lane: the pixel being accepted
  typedef struct packed {
    logic             acc;
    logic             blk_end;
    logic             clr;
    logic             dbl_h;
    logic             rd;
    logic [IDX_W-1:0] idx;
  } lane_a_t;

  // Column store update stage
  typedef struct packed {
    logic             valid;
    logic             row0;
    logic             dbl_v;
    logic             fwd;
    logic [IDX_W-1:0] idx;
  } lane_b_t;

  typedef struct packed {
    logic              adv;
    lane_a_t           a;
    lane_b_t           b;
    logic [FSEL_W-1:0] c_fsel;
    logic [FSEL_W-1:0] d_fsel;
  } lane_ctl_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic frame_end;
  } res_flags_t;

  // Reciprocal for exact floor division of a 16-bit sum by the block weight.
  // Weight is f*f, or 16 for the 1-2-1 kernel at f equal to 3.
  function automatic logic [RECIP_W-1:0] recip_mult(input logic [FSEL_W-1:0] fsel);
    logic [RECIP_W-1:0] m;
    case (fsel)
      4'd4:    m = 17'd83887;
      4'd5:    m = 17'd116509;
      4'd6:    m = 17'd85599;
      4'd8:    m = 17'd103564;
      4'd9:    m = 17'd83887;
      4'd10:   m = 17'd69328;
      4'd11:   m = 17'd116509;
      4'd12:   m = 17'd99274;
      4'd13:   m = 17'd85599;
      4'd14:   m = 17'd74566;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] recip_shift(input logic [FSEL_W-1:0] fsel);
    logic [SHIFT_W-1:0] s;
    case (fsel)
      4'd0:    s = 5'd16;
      4'd1:    s = 5'd18;
      4'd2:    s = 5'd20;
      4'd3:    s = 5'd20;
      4'd4:    s = 5'd21;
      4'd5:    s = 5'd22;
      4'd6:    s = 5'd22;
      4'd7:    s = 5'd22;
      4'd8:    s = 5'd23;
      4'd9:    s = 5'd23;
      4'd10:   s = 5'd23;
      default: s = 5'd24;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/ibd_ctrl.sv =====
module ibd_ctrl import ibd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  input  logic                  adv,
  output logic                  color_mode,
  output lane_ctl_t             ctl,
  output res_flags_t            res
);

  logic [FACTOR_W-1:0] factor;
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;

  logic [IDX_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [FSEL_W-1:0] column_in_block;
  logic [FSEL_W-1:0] row_in_block;

  logic [FACTOR_W-1:0] f_eff;
  logic [LIM_W-1:0]    w_ext;
  logic [LIM_W-1:0]    w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [FSEL_W-1:0]   fsel;
  logic                is3;
  logic                acc;
  logic                blk_end;
  logic                rib_end;
  logic                emit;
  logic                row_last;
  logic                frame_last;
  logic                rend;
  logic                fend;

  // B, C and D stage control
  lane_b_t           b;
  logic              b_emit;
  logic              b_rend;
  logic              b_fend;
  logic [FSEL_W-1:0] b_fsel;
  logic              c_valid;
  logic              c_rend;
  logic              c_fend;
  logic [FSEL_W-1:0] c_fsel;
  logic              d_valid;
  logic              d_rend;
  logic              d_fend;
  logic [FSEL_W-1:0] d_fsel;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      factor       <= FACTOR_W'(2);
      color_mode   <= 1'b0;
      image_width  <= WIDTH_W'(MAX_WIDTH);
      image_height <= HEIGHT_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FACTOR:       factor       <= cfg_data[FACTOR_W-1:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Clamp the settings to their legal ranges
  always_comb begin
    if (factor == '0) begin
      f_eff = FACTOR_W'(1);
    end else if (factor > FACTOR_W'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = factor;
    end
    w_ext = LIM_W'(image_width);
    if (w_ext == '0) begin
      w_eff = LIM_W'(1);
    end else if (w_ext > LIM_W'(MAX_WIDTH)) begin
      w_eff = LIM_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (image_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // Block and raster position of the pixel at the input
  assign fsel       = FSEL_W'(f_eff - 1'b1);
  assign is3        = (f_eff == FACTOR_W'(3));
  assign acc        = pixel_valid && adv;
  assign blk_end    = (FACTOR_W'(column_in_block) + 1'b1) >= f_eff;
  assign rib_end    = (FACTOR_W'(row_in_block) + 1'b1) >= f_eff;
  assign emit       = blk_end && rib_end;
  assign row_last   = (LIM_W'(column_count) + 1'b1) >= w_eff;
  assign frame_last = ((HEIGHT_W + 1)'(row_count) + 1'b1) >= (HEIGHT_W + 1)'(h_eff);
  assign rend       = (LIM_W'(column_count) + LIM_W'(f_eff)) >= w_eff;
  assign fend       = rend &&
                      (((HEIGHT_W + 1)'(row_count) + (HEIGHT_W + 1)'(f_eff)) >=
                       (HEIGHT_W + 1)'(h_eff));

  // Advance the raster counters on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
    end else if (acc) begin
      if (blk_end) begin
        column_in_block <= '0;
      end else begin
        column_in_block <= column_in_block + 1'b1;
      end
      if (row_last) begin
        column_count    <= '0;
        column_in_block <= '0;
        if (frame_last) begin
          row_count    <= '0;
          row_in_block <= '0;
        end else begin
          row_count    <= row_count + 1'b1;
          row_in_block <= rib_end ? '0 : row_in_block + 1'b1;
        end
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Stage control, frozen while the output holds a word and another waits
  always_ff @(posedge clk) begin
    if (rst) begin
      b.valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      b.valid <= acc && blk_end;
      c_valid <= b.valid && b_emit;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b.row0  <= (row_in_block == '0);
      b.dbl_v <= is3 && (row_in_block == FSEL_W'(1));
      b.fwd   <= b.valid && (b.idx == column_count);
      b.idx   <= column_count;
      b_emit  <= emit;
      b_rend  <= rend;
      b_fend  <= fend;
      b_fsel  <= fsel;
      c_rend  <= b_rend;
      c_fend  <= b_fend;
      c_fsel  <= b_fsel;
      d_rend  <= c_rend;
      d_fend  <= c_fend;
      d_fsel  <= c_fsel;
    end
  end

  always_comb begin
    ctl.adv       = adv;
    ctl.a.acc     = acc;
    ctl.a.blk_end = blk_end;
    ctl.a.clr     = blk_end || row_last;
    ctl.a.dbl_h   = is3 && (column_in_block == FSEL_W'(1));
    ctl.a.rd      = acc && blk_end && (row_in_block != '0);
    ctl.a.idx     = column_count;
    ctl.b         = b;
    ctl.c_fsel    = c_fsel;
    ctl.d_fsel    = d_fsel;
    res.valid     = d_valid;
    res.row_end   = d_rend;
    res.frame_end = d_fend;
  end

endmodule

// ===== hw/rtl/ibd_lane.sv =====
module ibd_lane import ibd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [PIX_W-1:0] px,
  input  lane_ctl_t        ctl,
  output logic [PIX_W-1:0] result
);

  logic [LANE_W-1:0] running_sum;
  logic [LANE_W-1:0] rs_new;
  logic [LANE_W-1:0] b_rs;
  logic [LANE_W-1:0] rd_data;
  logic [LANE_W-1:0] fwd_data;
  logic [LANE_W-1:0] cs_base;
  logic [LANE_W-1:0] cs;
  logic [LANE_W-1:0] c_cs;
  logic [PROD_W-1:0] d_prod;
  logic [PROD_W-1:0] q;
  logic [LANE_W-1:0] column_sums [MAX_WIDTH];

  // Horizontal partial sum, center tap doubled for the 1-2-1 kernel
  assign rs_new = running_sum +
                  (ctl.a.dbl_h ? LANE_W'({px, 1'b0}) : LANE_W'(px));

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (ctl.a.acc) begin
      running_sum <= ctl.a.clr ? '0 : rs_new;
    end
  end

  // Hand the finished horizontal sum to the column update
  always_ff @(posedge clk) begin
    if (ctl.a.acc && ctl.a.blk_end) begin
      b_rs <= rs_new;
    end
  end

  // Column store: read at the block's last column, write back one stage later
  always_ff @(posedge clk) begin
    if (ctl.a.rd) begin
      rd_data <= column_sums[ctl.a.idx];
    end
    if (ctl.adv && ctl.b.valid) begin
      column_sums[ctl.b.idx] <= cs;
    end
  end

  // Bypass the entry written in the same cycle as its read
  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.b.valid) begin
      fwd_data <= cs;
    end
  end

  always_comb begin
    if (ctl.b.row0) begin
      cs_base = '0;
    end else if (ctl.b.fwd) begin
      cs_base = fwd_data;
    end else begin
      cs_base = rd_data;
    end
    cs = cs_base + (ctl.b.dbl_v ? {b_rs[LANE_W-2:0], 1'b0} : b_rs);
  end

  // Divide by the block weight through a reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      c_cs   <= cs;
      d_prod <= PROD_W'(c_cs) * PROD_W'(recip_mult(ctl.c_fsel));
    end
  end

  // Shift down and saturate
  always_comb begin
    q      = d_prod >> recip_shift(ctl.d_fsel);
    result = (q > PROD_W'(255)) ? PIX_W'(255) : q[PIX_W-1:0];
  end

endmodule

// ===== hw/rtl/ibd_merge.sv =====
module ibd_merge import ibd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [PIX_W-1:0] lane0,
  input  logic [PIX_W-1:0] lane1,
  input  logic [PIX_W-1:0] lane2,
  input  res_flags_t       res,
  input  logic             result_stall,
  output logic             result_valid,
  output logic [PIX_W-1:0] out_ch0,
  output logic [PIX_W-1:0] out_ch1,
  output logic [PIX_W-1:0] out_ch2,
  output logic             row_end,
  output logic             frame_end,
  output logic             adv
);

  logic out_free;

  // Output register frees when empty or taken; pipeline holds only when a
  // word waits behind a stalled one
  assign out_free = !result_valid || !result_stall;
  assign adv      = out_free || !res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= res.valid;
    end
  end

  // Combine the channel lanes with the raster flags
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_ch0   <= lane0;
      out_ch1   <= lane1;
      out_ch2   <= lane2;
      row_end   <= res.row_end;
      frame_end <= res.frame_end;
    end
  end

endmodule

// ===== hw/rtl/image_block_downscaler.sv =====
// Box-filter downscaler. Pixels enter in raster order, one per clock, and one
// averaged pixel leaves for every complete factor-by-factor block; for factor
// 3 the block is weighted 1-2-1 in both directions and divided by 16. Each
// of the three channels runs in its own lane with a 2048-entry column store
// that is read at a block's last column and written back from stage B, a
// bypass covering back-to-back blocks on the same column. A result for a
// block passes stages B, C, D and the output register. The block takes one
// pixel every clock; pixel_stall rises only while a result sits stalled in
// the output register and the next result has reached the end of the lanes.
// Registers are written through the cfg port, which is always ready; write
// them only between frames or with the block drained.
module image_block_downscaler import ibd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [PIX_W-1:0]      pixel_ch0,
  input  logic [PIX_W-1:0]      pixel_ch1,
  input  logic [PIX_W-1:0]      pixel_ch2,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PIX_W-1:0]      out_ch0,
  output logic [PIX_W-1:0]      out_ch1,
  output logic [PIX_W-1:0]      out_ch2,
  output logic                  row_end,
  output logic                  frame_end
);

  lane_ctl_t        ctl;
  res_flags_t       res;
  logic             adv;
  logic             color_mode;
  logic [PIX_W-1:0] px1;
  logic [PIX_W-1:0] px2;
  logic [PIX_W-1:0] lane0;
  logic [PIX_W-1:0] lane1;
  logic [PIX_W-1:0] lane2;

  assign pixel_stall = !adv;

  // Drop the color channels in grey mode
  assign px1 = color_mode ? pixel_ch1 : '0;
  assign px2 = color_mode ? pixel_ch2 : '0;

  ibd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .adv         (adv),
    .color_mode  (color_mode),
    .ctl         (ctl),
    .res         (res)
  );

  ibd_lane u_lane0 (
    .clk    (clk),
    .rst    (rst),
    .px     (pixel_ch0),
    .ctl    (ctl),
    .result (lane0)
  );

  ibd_lane u_lane1 (
    .clk    (clk),
    .rst    (rst),
    .px     (px1),
    .ctl    (ctl),
    .result (lane1)
  );

  ibd_lane u_lane2 (
    .clk    (clk),
    .rst    (rst),
    .px     (px2),
    .ctl    (ctl),
    .result (lane2)
  );

  ibd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .lane0        (lane0),
    .lane1        (lane1),
    .lane2        (lane2),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .adv          (adv)
  );

endmodule

// ===== hw/rtl/ibd_checker.sv =====
module ibd_checker (
  input logic clk,
  input logic rst,
  input logic pixel_valid,
  input logic pixel_stall,
  input logic result_valid,
  input logic result_stall,
  input logic row_end,
  input logic frame_end
);

  // A stalled result word stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  // The last word of a frame also closes its row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("input stalled with output free");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word offered after reset");

endmodule

bind image_block_downscaler ibd_checker u_ibd_checker (.*);

// ===== sim/image_block_downscaler_checker.sv =====
`timescale 1ns / 1ps

module image_block_downscaler_checker import ibd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  input  logic                  pixel_stall,
  input  logic [PIX_W-1:0]      pixel_ch0,
  input  logic [PIX_W-1:0]      pixel_ch1,
  input  logic [PIX_W-1:0]      pixel_ch2,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic [PIX_W-1:0]      out_ch0,
  input  logic [PIX_W-1:0]      out_ch1,
  input  logic [PIX_W-1:0]      out_ch2,
  input  logic                  row_end,
  input  logic                  frame_end,
  output int                    mismatch_count,
  output int                    backlog
);

  typedef logic [2:0][LANE_W-1:0] lane_sums_t;

  typedef struct packed {
    logic [2:0][PIX_W-1:0] ch;
    logic                  row_end;
    logic                  frame_end;
  } box_pixel_t;

  // Shadow registers
  logic [FACTOR_W-1:0] factor_q;
  logic                color_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  // Own copy of the line store and block counters
  lane_sums_t  column_partial [MAX_WIDTH];
  lane_sums_t  row_partial;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned col_in_blk;
  int unsigned row_in_blk;

  box_pixel_t averages_due[$];
  int         errors = 0;

  // Fold one pixel into the running sums; queue the block average it completes
  task automatic average_block(input logic [PIX_W-1:0] p0, p1, p2);
    int unsigned f, w, h, hw, vw, dv, v, idx;
    int unsigned px [3];
    lane_sums_t  cs;
    box_pixel_t  avg;
    f = (factor_q == 0) ? 1 : ((factor_q > MAX_FACTOR) ? MAX_FACTOR : factor_q);
    w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
    h = (height_q == 0) ? 1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q);
    px[0] = p0;
    px[1] = color_q ? p1 : 0;
    px[2] = color_q ? p2 : 0;
    // middle tap of the 1-2-1 kernel counts twice
    hw = (f == 3 && col_in_blk == 1) ? 2 : 1;
    for (int k = 0; k < 3; k++) row_partial[k] = LANE_W'(row_partial[k] + hw * px[k]);

    if (col_in_blk + 1 >= f) begin
      idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
      vw = (f == 3 && row_in_blk == 1) ? 2 : 1;
      cs = (row_in_blk == 0) ? '0 : column_partial[idx];
      for (int k = 0; k < 3; k++) cs[k] = LANE_W'(cs[k] + vw * row_partial[k]);
      column_partial[idx] = cs;
      row_partial = '0;
      col_in_blk = 0;
      // last row of the block: emit the average, saturated
      if (row_in_blk + 1 >= f) begin
        dv = (f == 3) ? 16 : f * f;
        for (int k = 0; k < 3; k++) begin
          v = cs[k] / dv;
          avg.ch[k] = (v > 255) ? 8'hFF : v[7:0];
        end
        avg.row_end = (col_pos + f >= w);
        avg.frame_end = avg.row_end && (row_pos + f >= h);
        averages_due.push_back(avg);
      end
    end else begin
      col_in_blk++;
    end

    // advance raster position
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      col_in_blk = 0;
      row_partial = '0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        row_in_blk = 0;
      end else begin
        row_pos++;
        row_in_blk = (row_in_blk + 1 >= f) ? 0 : row_in_blk + 1;
      end
    end else begin
      col_pos++;
    end
  endtask

  // Compare one output word against the oldest pending average
  task automatic check_average();
    box_pixel_t            want;
    logic [2:0][PIX_W-1:0] seen;
    seen = {out_ch2, out_ch1, out_ch0};
    if (averages_due.size() == 0) begin
      errors++;
      $display("%0t: expected no word, got ch %0d %0d %0d row_end %0b frame_end %0b",
               $time, out_ch0, out_ch1, out_ch2, row_end, frame_end);
    end else begin
      want = averages_due.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (want.ch[k] !== seen[k]) begin
          errors++;
          $display("%0t: out_ch%0d expected %0d, got %0d", $time, k, want.ch[k], seen[k]);
        end
      end
      if (want.row_end !== row_end) begin
        errors++;
        $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, row_end);
      end
      if (want.frame_end !== frame_end) begin
        errors++;
        $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end, frame_end);
      end
    end
  endtask

  // Track register writes, accepted pixels and taken results at each edge
  always @(posedge clk) begin
    if (rst) begin
      factor_q = 5'd2;
      color_q = 1'b0;
      width_q = 12'd2048;
      height_q = 13'd4096;
      row_partial = '0;
      col_pos = 0;
      row_pos = 0;
      col_in_blk = 0;
      row_in_blk = 0;
      averages_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FACTOR:       factor_q = cfg_data[FACTOR_W-1:0];
          REG_COLOR_MODE:   color_q = cfg_data[0];
          REG_IMAGE_WIDTH:  width_q = cfg_data[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_q = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) check_average();
      if (pixel_valid && !pixel_stall) average_block(pixel_ch0, pixel_ch1, pixel_ch2);
    end
    backlog <= averages_due.size();
    mismatch_count <= errors;
  end

endmodule

// ===== sim/image_block_downscaler_test.sv =====
`timescale 1ns / 1ps

module image_block_downscaler_test;
  import ibd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned PHASE_PIXELS = 140;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  logic [PIX_W-1:0]      pixel_ch0 = '0;
  logic [PIX_W-1:0]      pixel_ch1 = '0;
  logic [PIX_W-1:0]      pixel_ch2 = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [PIX_W-1:0]      out_ch0;
  logic [PIX_W-1:0]      out_ch1;
  logic [PIX_W-1:0]      out_ch2;
  logic                  row_end;
  logic                  frame_end;

  int          mismatches;
  int          backlog;
  int unsigned cycles = 0;
  int unsigned send_idle = 15;
  int unsigned stall_pct = 75;

  image_block_downscaler u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_ch0    (pixel_ch0),
    .pixel_ch1    (pixel_ch1),
    .pixel_ch2    (pixel_ch2),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

  image_block_downscaler_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel_ch0      (pixel_ch0),
    .pixel_ch1      (pixel_ch1),
    .pixel_ch2      (pixel_ch2),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_ch0        (out_ch0),
    .out_ch1        (out_ch1),
    .out_ch2        (out_ch2),
    .row_end        (row_end),
    .frame_end      (frame_end),
    .mismatch_count (mismatches),
    .backlog        (backlog)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the output side at random
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rand_level();
    logic [PIX_W-1:0] v;
    case ($urandom_range(7))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  // Hold a pixel word until taken, then idle now and then
  task automatic push_pixel(input logic [PIX_W-1:0] c0, c1, c2);
    pixel_valid <= 1'b1;
    pixel_ch0 <= c0;
    pixel_ch1 <= c1;
    pixel_ch2 <= c2;
    do @(posedge clk); while (pixel_stall);
    if ($urandom_range(99) < send_idle) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Send n pixels, random when fill is negative, else all channels at fill
  task automatic send_frame(input int unsigned n, input int fill);
    for (int unsigned i = 0; i < n; i++) begin
      if (fill < 0) push_pixel(rand_level(), rand_level(), rand_level());
      else push_pixel(8'(fill), 8'(fill), 8'(fill));
    end
  endtask

  // Drop valid, wait for every pending average, then let the pipeline empty
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int unsigned v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= CFG_DATA_W'(v);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram all registers with the block drained
  task automatic set_geometry(input int unsigned f, c, w, h);
    settle();
    write_reg(REG_FACTOR, f);
    write_reg(REG_COLOR_MODE, c);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Force every counter back to zero: a 1x1 frame ends at once
  task automatic realign();
    set_geometry(1, 0, 1, 1);
    send_frame(1, -1);
  endtask

  // One frame of random shape; a few are cut short and then realigned
  task automatic random_frame(inout int unsigned taken);
    int unsigned f, fv, wd, ht, wv, hv, n;
    bit          cut;
    case ($urandom_range(9))
      0:       f = $urandom_range(7, MAX_FACTOR);
      1, 2:    f = 3;
      default: f = $urandom_range(1, 6);
    endcase
    if (f > 6) begin
      wd = f + $urandom_range(0, 3);
      ht = f;
    end else begin
      wd = f * $urandom_range(1, 3) + $urandom_range(0, f - 1);
      ht = f * $urandom_range(1, 2) + $urandom_range(0, f - 1);
    end
    // now and then a frame too small for any block
    if (f > 1 && $urandom_range(9) == 0) begin
      if ($urandom_range(1)) wd = $urandom_range(1, f - 1);
      else ht = $urandom_range(1, f - 1);
    end
    // out-of-range encodings of the same effective values
    fv = f;
    if (f == 1 && $urandom_range(1)) fv = 0;
    if (f == MAX_FACTOR && $urandom_range(1)) fv = $urandom_range(MAX_FACTOR + 1, 31);
    wv = (wd == 1 && $urandom_range(1)) ? 0 : wd;
    hv = (ht == 1 && $urandom_range(1)) ? 0 : ht;
    n = wd * ht;
    cut = ($urandom_range(7) == 0);
    if (cut) n = $urandom_range(1, n);
    set_geometry(fv, $urandom_range(1), wv, hv);
    send_frame(n, -1);
    if (cut) realign();
    taken += n;
  endtask

  initial begin
    int unsigned taken;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Factor zero acts as one, width past the store; seeds the first store entries
    set_geometry(0, 1, 4095, 1);
    send_frame(64, -1);
    realign();
    // Single column, height past its limit
    set_geometry(1, 0, 0, 8191);
    send_frame(40, -1);
    realign();
    // Largest block at full scale, factor field above range
    set_geometry(31, 1, 16, 16);
    send_frame(256, 255);
    // Weighted 3x3 kernel
    set_geometry(3, 1, 3, 3);
    send_frame(9, 255);
    send_frame(9, -1);
    // Grey mode ignores the colour channels; edge rows and columns dropped
    set_geometry(2, 0, 5, 5);
    send_frame(25, -1);
    // Height zero acts as one
    set_geometry(1, 1, 3, 0);
    send_frame(3, -1);
    // Block larger than the frame: no output
    set_geometry(4, 1, 3, 3);
    send_frame(9, -1);
    // Shrink the factor mid-block so the sums saturate
    set_geometry(4, 1, 8, 8);
    send_frame(24, 255);
    set_geometry(2, 1, 8, 8);
    send_frame(8, 255);
    // Cut the width under the column count mid-row
    send_frame(5, -1);
    set_geometry(2, 1, 2, 8);
    send_frame(1, -1);
    realign();

    // Random frames under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 15;
          stall_pct = 75;
        end
        1: begin
          send_idle = 75;
          stall_pct = 15;
        end
        default: begin
          send_idle = 0;
          stall_pct = 0;
        end
      endcase
      taken = 0;
      while (taken < PHASE_PIXELS) random_frame(taken);
    end

    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== image_block_downscaler.f =====
hw/rtl/ibd_pkg.sv
hw/rtl/ibd_ctrl.sv
hw/rtl/ibd_lane.sv
hw/rtl/ibd_merge.sv
hw/rtl/image_block_downscaler.sv
hw/rtl/ibd_checker.sv
sim/image_block_downscaler_checker.sv
sim/image_block_downscaler_test.sv
